/* sv/spk_pkg.sv */
// Shared types, variant tables and rotation helpers for the Speck cipher block.
`timescale 1ns / 1ps
`default_nettype none

package spk_pkg;

	// Round key store depth and its address width.
	localparam int MAX_ROUNDS = 34;
	localparam int RK_AW = $clog2(MAX_ROUNDS);
	localparam int WORD_W = 64;
	localparam int NUM_VARIANTS = 10;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_VARIANT = 3'd0;
	localparam logic [2:0] REG_KEY0 = 3'd1;
	localparam logic [2:0] REG_KEY1 = 3'd2;
	localparam logic [2:0] REG_KEY2 = 3'd3;
	localparam logic [2:0] REG_KEY3 = 3'd4;

	// Word size of the selected variant.
	typedef enum logic [2:0] {
		W16 = 3'd0,
		W24 = 3'd1,
		W32 = 3'd2,
		W48 = 3'd3,
		W64 = 3'd4
	} wsel_t;

	// Operands of one round, shared by encryption, decryption and key expansion.
	typedef struct packed {
		logic dec;
		wsel_t wsel;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] key;
	} round_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} round_out_t;

	function automatic logic var_valid(input logic [3:0] v);
		return v < 4'(NUM_VARIANTS);
	endfunction

	function automatic logic [RK_AW-1:0] var_rounds(input logic [3:0] v);
		logic [RK_AW-1:0] r;
		case (v)
			4'd0: r = RK_AW'(22);
			4'd1: r = RK_AW'(22);
			4'd2: r = RK_AW'(23);
			4'd3: r = RK_AW'(26);
			4'd4: r = RK_AW'(27);
			4'd5: r = RK_AW'(28);
			4'd6: r = RK_AW'(29);
			4'd7: r = RK_AW'(32);
			4'd8: r = RK_AW'(33);
			4'd9: r = RK_AW'(34);
			default: r = RK_AW'(MAX_ROUNDS);
		endcase
		return r;
	endfunction

	// Number of key words; the schedule keeps nk-1 of them in the l registers.
	function automatic logic [2:0] var_nk(input logic [3:0] v);
		logic [2:0] n;
		case (v)
			4'd0, 4'd2, 4'd4, 4'd9: n = 3'd4;
			4'd1, 4'd3, 4'd6, 4'd8: n = 3'd3;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic wsel_t var_wsel(input logic [3:0] v);
		wsel_t w;
		case (v)
			4'd0: w = W16;
			4'd1, 4'd2: w = W24;
			4'd3, 4'd4: w = W32;
			4'd5, 4'd6: w = W48;
			default: w = W64;
		endcase
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] width_mask(input int w);
		return (w >= WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic int wsel_bits(input wsel_t ws);
		int b;
		case (ws)
			W16: b = 16;
			W24: b = 24;
			W32: b = 32;
			W48: b = 48;
			default: b = 64;
		endcase
		return b;
	endfunction

	function automatic logic [WORD_W-1:0] word_mask(input wsel_t ws);
		return width_mask(wsel_bits(ws));
	endfunction

	// Rotations on a word already masked to w bits.
	function automatic logic [WORD_W-1:0] rot_r(input logic [WORD_W-1:0] x, input int n,
			input int w);
		return ((x >> n) | (x << (w - n))) & width_mask(w);
	endfunction

	function automatic logic [WORD_W-1:0] rot_l(input logic [WORD_W-1:0] x, input int n,
			input int w);
		return ((x << n) | (x >> (w - n))) & width_mask(w);
	endfunction

	// The 16-bit word size is the only one with rotations 7 and 2.
	function automatic logic [WORD_W-1:0] rotr_a(input logic [WORD_W-1:0] x, input wsel_t ws);
		return (ws == W16) ? rot_r(x, 7, 16) : rot_r(x, 8, wsel_bits(ws));
	endfunction

	function automatic logic [WORD_W-1:0] rotl_a(input logic [WORD_W-1:0] x, input wsel_t ws);
		return (ws == W16) ? rot_l(x, 7, 16) : rot_l(x, 8, wsel_bits(ws));
	endfunction

	function automatic logic [WORD_W-1:0] rotr_b(input logic [WORD_W-1:0] x, input wsel_t ws);
		return (ws == W16) ? rot_r(x, 2, 16) : rot_r(x, 3, wsel_bits(ws));
	endfunction

	function automatic logic [WORD_W-1:0] rotl_b(input logic [WORD_W-1:0] x, input wsel_t ws);
		return (ws == W16) ? rot_l(x, 2, 16) : rot_l(x, 3, wsel_bits(ws));
	endfunction

endpackage

`default_nettype wire

/* sv/spk_round_unit.sv */
// Shared Speck round unit: one forward or inverse round per cycle, also used for key expansion.
`timescale 1ns / 1ps
`default_nettype none

module spk_round_unit
	import spk_pkg::*;
(
	input  wire round_in_t  rin,
	output round_out_t      rout
);

	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] enc_x;
	logic [WORD_W-1:0] dec_y;

	// Forward round: x = (x >>> a) + y ^ k, y = (y <<< b) ^ x.
	// Inverse round: y = (y ^ x) >>> b, x = ((x ^ k) - y) <<< a.
	always_comb begin
		mask = word_mask(rin.wsel);
		sum = (rotr_a(rin.x, rin.wsel) + rin.y) & mask;
		enc_x = sum ^ rin.key;
		dec_y = rotr_b(rin.y ^ rin.x, rin.wsel);
		diff = ((rin.x ^ rin.key) - dec_y) & mask;
		if (rin.dec) begin
			rout.x = rotl_a(diff, rin.wsel);
			rout.y = dec_y;
		end else begin
			rout.x = enc_x;
			rout.y = rotl_b(rin.y, rin.wsel) ^ enc_x;
		end
	end

endmodule

`default_nettype wire

/* sv/speck_block_cipher.sv */
// Speck block cipher top level: configuration, key schedule store and round sequencer.
// A block is accepted in the idle state, then runs through its rounds (22..34 by variant)
// and is loaded into the output register once that register is free or being read; an
// undefined variant skips the rounds. The single shared round unit takes a new block only
// after the last one is loaded. Reset and every configuration write start a key expansion
// (skipped for an undefined variant) that fills the round key store; no block is accepted until it ends.
// Reset is asynchronous and active low and clears all configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module speck_block_cipher
	import spk_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	// Configuration write port.
	input  wire          cfg_we,
	input  wire  [2:0]   cfg_idx,
	input  wire  [63:0]  cfg_data,
	// Block requests.
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [127:0] s_axis_tdata,    // block_low [63:0], block_high [127:64]
	input  wire          s_axis_tuser,    // req_type [0]
	// Cipher results.
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [127:0] m_axis_tdata     // result_low [63:0], result_high [127:64]
);

	typedef enum logic [4:0] {
		ST_KLOAD = 5'b00001,
		ST_KEXP  = 5'b00010,
		ST_IDLE  = 5'b00100,
		ST_RUN   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	logic [3:0]        variant_q;
	logic [WORD_W-1:0] key_q [4];

	logic [RK_AW-1:0]  cnt_q;
	logic [RK_AW-1:0]  rem_q;
	logic              dec_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] k_q;
	logic [WORD_W-1:0] l_q [3];
	logic              out_vld_q;
	logic [127:0]      out_data_q;

	// Round key store.
	logic [WORD_W-1:0] rk_mem [MAX_ROUNDS];
	logic [WORD_W-1:0] rk_q;
	logic              rk_we;
	logic [RK_AW-1:0]  rk_waddr;
	logic [WORD_W-1:0] rk_wdata;
	logic              rk_re;
	logic [RK_AW-1:0]  rk_raddr;

	round_in_t  ru_in;
	round_out_t ru_out;

	logic [WORD_W-1:0] mask;
	logic [RK_AW-1:0]  rounds;
	logic [2:0]        nk;
	logic              vld_var;
	logic              in_acc;
	logic              out_load;
	logic              last_round;
	logic              last_key;

	assign mask = word_mask(var_wsel(variant_q));
	assign rounds = var_rounds(variant_q);
	assign nk = var_nk(variant_q);
	assign vld_var = var_valid(variant_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready);
	assign last_round = (rem_q == RK_AW'(1));
	assign last_key = (cnt_q == rounds - RK_AW'(2));

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;

	// Round unit operands: key schedule words while expanding, the block otherwise.
	always_comb begin
		ru_in.wsel = var_wsel(variant_q);
		if (state_q == ST_KEXP) begin
			ru_in.dec = 1'b0;
			ru_in.x = l_q[0];
			ru_in.y = k_q;
			ru_in.key = WORD_W'(cnt_q);
		end else begin
			ru_in.dec = dec_q;
			ru_in.x = x_q;
			ru_in.y = y_q;
			ru_in.key = rk_q;
		end
	end

	spk_round_unit u_round (
		.rin  (ru_in),
		.rout (ru_out)
	);

	// Store write during key expansion, read one round ahead during a block.
	always_comb begin
		rk_we = 1'b0;
		rk_waddr = cnt_q + RK_AW'(1);
		rk_wdata = ru_out.y;
		if (state_q == ST_KLOAD) begin
			rk_we = vld_var;
			rk_waddr = '0;
			rk_wdata = key_q[0] & mask;
		end else if (state_q == ST_KEXP) begin
			rk_we = 1'b1;
		end
		if (state_q == ST_IDLE) begin
			rk_re = in_acc;
			rk_raddr = s_axis_tuser ? rounds - RK_AW'(1) : '0;
		end else begin
			rk_re = (state_q == ST_RUN) && !last_round;
			rk_raddr = dec_q ? cnt_q - RK_AW'(1) : cnt_q + RK_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rk_we) begin
			rk_mem[rk_waddr] <= rk_wdata;
		end
		if (rk_re) begin
			rk_q <= rk_mem[rk_raddr];
		end
	end

	// Sequencer, configuration registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KLOAD;
			variant_q <= '0;
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
			cnt_q <= '0;
			rem_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// The output register fills on a load and empties when its result is taken.
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			// A configuration write restarts the key schedule.
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_VARIANT: variant_q <= cfg_data[3:0];
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					default: ;
				endcase
				state_q <= ST_KLOAD;
			end else begin
				unique case (state_q)
					ST_KLOAD: begin
						cnt_q <= '0;
						state_q <= vld_var ? ST_KEXP : ST_IDLE;
					end
					ST_KEXP: begin
						cnt_q <= cnt_q + RK_AW'(1);
						if (last_key) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_acc) begin
							cnt_q <= s_axis_tuser ? rounds - RK_AW'(1) : '0;
							rem_q <= rounds;
							state_q <= vld_var ? ST_RUN : ST_FIN;
						end
					end
					ST_RUN: begin
						cnt_q <= dec_q ? cnt_q - RK_AW'(1) : cnt_q + RK_AW'(1);
						rem_q <= rem_q - RK_AW'(1);
						if (last_round) begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						if (out_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_KLOAD;
					end
				endcase
			end
		end
	end

	// Block words, key schedule words and output data.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_KLOAD: begin
				k_q <= key_q[0] & mask;
				l_q[0] <= key_q[1] & mask;
				l_q[1] <= key_q[2] & mask;
				l_q[2] <= key_q[3] & mask;
			end
			ST_KEXP: begin
				k_q <= ru_out.y;
				case (nk)
					3'd2: begin
						l_q[0] <= ru_out.x;
					end
					3'd3: begin
						l_q[0] <= l_q[1];
						l_q[1] <= ru_out.x;
					end
					default: begin
						l_q[0] <= l_q[1];
						l_q[1] <= l_q[2];
						l_q[2] <= ru_out.x;
					end
				endcase
			end
			ST_IDLE: begin
				if (in_acc) begin
					dec_q <= s_axis_tuser;
					if (vld_var) begin
						y_q <= s_axis_tdata[63:0] & mask;
						x_q <= s_axis_tdata[127:64] & mask;
					end else begin
						y_q <= '0;
						x_q <= '0;
					end
				end
			end
			ST_RUN: begin
				x_q <= ru_out.x;
				y_q <= ru_out.y;
			end
			ST_FIN: begin
				if (out_load) begin
					out_data_q <= {x_q, y_q};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* sv/spk_checker.sv */
// Port-level checker for the Speck cipher block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spk_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         cfg_we,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [127:0] m_axis_tdata
);

	// A stalled result holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The block is busy in the cycle after it takes a request.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while a block is in progress");

	// A configuration write starts a key expansion, which blocks requests.
	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("request port ready right after a configuration write");

	// A new result appears only after the block was busy.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a busy cycle before it");

endmodule

bind speck_block_cipher spk_checker u_spk_checker (.*);

`default_nettype wire
